@@ design/sms_pkg.sv @@
// Shared types, constants and codes for the sorted matrix search block.
package sms_pkg;

  // Store geometry
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;

  // Field widths
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 6;
  localparam int CFG_W    = 7;
  localparam int CFG_IX_W = 2;

  // Register indexes
  localparam logic [CFG_IX_W-1:0] REG_ROWS = CFG_IX_W'(0);
  localparam logic [CFG_IX_W-1:0] REG_COLS = CFG_IX_W'(1);

  // Request function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  // Access to the element store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

endpackage

@@ design/sorted_matrix_search_top.sv @@
// Top level of the sorted matrix search block: sequencer, size registers and store.
//
// Holds a matrix of up to 64 x 64 signed 32-bit elements whose rows and
// columns rise. A load request writes one element and gives no result. A
// search request walks a staircase from the top-right element in use
// (larger element: step left, smaller: step down) and gives one result,
// found. Each step costs one read of the element store, one store read per
// cycle; the result then waits while out_stall is high, and an empty matrix
// goes straight to its result. in_stall stays high from an accepted search
// until its result has been taken. The user must set rows and columns in
// use through the configuration channel only while the block is idle; the
// block itself does not enforce it, and cfg_ready is always high.
module sorted_matrix_search_top (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [sms_pkg::IDX_W-1:0]     row_index,
  input  logic [sms_pkg::IDX_W-1:0]     col_index,
  input  logic signed [sms_pkg::DATA_W-1:0] element_value,
  input  logic signed [sms_pkg::DATA_W-1:0] search_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sms_pkg::CFG_IX_W-1:0]  cfg_index,
  input  logic [sms_pkg::CFG_W-1:0]     cfg_data
);
  import sms_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0]  rows_in_use, cols_in_use;
  logic [CFG_W-1:0]  rows_eff, cols_eff;
  logic [CFG_W-1:0]  r, r_next;
  logic [CFG_W-1:0]  cols_left, cols_left_next;
  logic [CFG_W-1:0]  r_inc, cols_dec;
  logic [DATA_W-1:0] target, target_next;
  logic              found_next;
  logic              load_ok;
  logic [DATA_W-1:0] rd_data;
  store_req_t        req;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= '0;
      cols_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROWS) begin
        rows_in_use <= cfg_data;
      end else if (cfg_index == REG_COLS) begin
        cols_in_use <= cfg_data;
      end
    end
  end

  // sizes saturated to the store
  assign rows_eff = (rows_in_use > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_in_use;
  assign cols_eff = (cols_in_use > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cols_in_use;

  assign load_ok  = ({1'b0, row_index} < CFG_W'(MAX_ROWS)) &&
                    ({1'b0, col_index} < CFG_W'(MAX_COLS));
  assign r_inc    = r + CFG_W'(1);
  assign cols_dec = cols_left - CFG_W'(1);

  // element store
  sms_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // walk position, target and answer
  always_ff @(posedge clk) begin
    r         <= r_next;
    cols_left <= cols_left_next;
    target    <= target_next;
    found     <= found_next;
  end

  // next state, walk step and store access
  always_comb begin
    state_next     = state;
    r_next         = r;
    cols_left_next = cols_left;
    target_next    = target;
    found_next     = found;
    req            = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_LOAD) begin
            if (load_ok) begin
              req.wr_en   = 1'b1;
              req.wr_addr = {row_index[ROW_W-1:0], col_index[COL_W-1:0]};
              req.wr_data = element_value;
            end
          end else begin
            target_next    = search_value;
            r_next         = '0;
            cols_left_next = cols_eff;
            found_next     = 1'b0;
            if (rows_eff == '0 || cols_eff == '0) begin
              state_next = ST_DONE;
            end else begin
              // fetch the top-right element
              state_next  = ST_WALK;
              req.rd_en   = 1'b1;
              req.rd_addr = {ROW_W'(0), COL_W'(cols_eff - CFG_W'(1))};
            end
          end
        end
      end
      ST_WALK: begin
        if (rd_data == target) begin
          found_next = 1'b1;
          state_next = ST_DONE;
        end else if ($signed(rd_data) > $signed(target)) begin
          // step left
          if (cols_dec == '0) begin
            state_next = ST_DONE;
          end else begin
            cols_left_next = cols_dec;
            req.rd_en      = 1'b1;
            req.rd_addr    = {r[ROW_W-1:0], COL_W'(cols_dec - CFG_W'(1))};
          end
        end else begin
          // step down
          if (r_inc == rows_eff) begin
            state_next = ST_DONE;
          end else begin
            r_next      = r_inc;
            req.rd_en   = 1'b1;
            req.rd_addr = {r_inc[ROW_W-1:0], COL_W'(cols_dec)};
          end
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);

endmodule

@@ design/sms_store.sv @@
// Element store: one write port, one read port with registered read data.
module sms_store (
  input  logic                      clk,
  input  sms_pkg::store_req_t       req,
  output logic [sms_pkg::DATA_W-1:0] rd_data
);
  import sms_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, data valid the cycle after the address
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ design/sms_check.sv @@
// Port-level checker for the sorted matrix search block, with its bind.
module sms_check (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic func,
  input logic out_valid,
  input logic out_stall,
  input logic found
);
  import sms_pkg::*;

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(found)))
    else $error("stalled result changed");

  // no new request taken while a result waits
  a_busy_on_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request side open while result pending");

  // a search request closes the request side
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && func == FUNC_SEARCH) |=> in_stall)
    else $error("search accepted without going busy");

  // one result per search
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated");

endmodule

bind sorted_matrix_search_top sms_check u_sms_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .func      (func),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .found     (found)
);
